>>> design/assert_macros.svh
// Assertion macros for the design files; tagged_free_run_finder_unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: overlapping implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/tfrf_pkg.sv
package tfrf_pkg;

    localparam int ADDR_BITS      = 24;
    localparam int BANK_BITS      = 15;
    localparam int SIZE_BITS      = 15;
    localparam int RUN_BITS       = 16;
    localparam int SKIP_BITS      = 17;
    localparam int FILL_BITS      = 3;
    localparam int WIN_BYTES      = 8;
    localparam int HEADER_BYTES   = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [RUN_BITS-1:0]  run_t;
    typedef logic [SKIP_BITS-1:0] skip_t;
    typedef logic [FILL_BITS-1:0] fill_t;
    typedef logic [WIN_BYTES-1:0][7:0] window_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_REQ_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_ADDR = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AGGRESSIVE = 2'd2;

    localparam size_t REQ_SIZE_RESET   = 15'd1;
    localparam addr_t START_ADDR_RESET = 24'h080000;

    // Tag letters in window order: byte 0 in the low bits.
    localparam logic [31:0] TAG_MAGIC = 32'h52415453;

    typedef struct packed {
        addr_t pos;
        run_t  run;
        skip_t skip;
        logic  done;
        addr_t maddr;
    } scan_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

>>> design/tfrf_judge.sv
module tfrf_judge (
    input  tfrf_pkg::scan_t   cur,
    input  tfrf_pkg::window_t win,
    input  logic              full,
    input  tfrf_pkg::size_t   req_size,
    input  logic              aggressive,
    output tfrf_pkg::scan_t   nxt
);

    tfrf_pkg::run_t need;
    tfrf_pkg::run_t base_run;
    logic           tag_hit;
    logic [15:0]    tag_size;
    logic [15:0]    tag_inv;

    always_comb
    begin
        need     = tfrf_pkg::run_t'(req_size) + tfrf_pkg::run_t'(tfrf_pkg::HEADER_BYTES);
        base_run = (cur.pos[tfrf_pkg::BANK_BITS-1:0] == '0) ? '0 : cur.run;
        tag_hit  = full && ({win[3], win[2], win[1], win[0]} == tfrf_pkg::TAG_MAGIC);
        tag_size = {win[5], win[4]};
        tag_inv  = {win[7], win[6]};
        nxt      = cur;
        if (cur.done)
        begin
            nxt = cur;
        end
        else if (cur.skip != '0)
        begin
            nxt.skip = cur.skip - 1'b1;
        end
        else if (cur.run == need)
        begin
            nxt.done  = 1'b1;
            nxt.maddr = cur.pos - tfrf_pkg::addr_t'(need);
        end
        else if (tag_hit)
        begin
            if (tag_size != ~tag_inv)
            begin
                nxt.run = base_run + 1'b1;
            end
            else
            begin
                nxt.skip = tfrf_pkg::skip_t'(tag_size)
                         + tfrf_pkg::skip_t'(tfrf_pkg::HEADER_BYTES);
                nxt.run  = '0;
            end
        end
        else if (win[0] == 8'h00 || aggressive)
        begin
            nxt.run = base_run + 1'b1;
        end
        else
        begin
            nxt.run = '0;
        end
    end

endmodule

>>> design/tagged_free_run_finder_unit.sv
// Throughput: one image byte per cycle while the scan runs.
// Result: after the last byte is accepted, ST_DRAIN judges the k bytes (1 to 7) still in
// the lookahead window, one byte per cycle, and ST_FINISH then registers the result beat
// once the output register is free; in_stall is high in both states.
// Reset (rst_n, asynchronous, active low): all but the result registers reset, and the
// scan starts at the reset start address with an empty window and no result pending.
`include "assert_macros.svh"

module tagged_free_run_finder_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tfrf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tfrf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             rom_byte,
    input  logic                                   last_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   found,
    output tfrf_pkg::addr_t                        region_start
);

    tfrf_pkg::size_t   req_size_reg;
    tfrf_pkg::addr_t   start_addr_reg;
    logic              aggressive_reg;
    tfrf_pkg::state_t  state_reg;
    tfrf_pkg::state_t  state_next;
    tfrf_pkg::scan_t   scan_reg;
    tfrf_pkg::scan_t   scan_next;
    tfrf_pkg::window_t win_reg;
    tfrf_pkg::window_t win_next;
    tfrf_pkg::fill_t   fill_reg;
    tfrf_pkg::fill_t   fill_next;
    logic              out_valid_reg;
    logic              found_reg;
    tfrf_pkg::addr_t   region_start_reg;

    tfrf_pkg::window_t entry_win;
    tfrf_pkg::window_t judge_win;
    tfrf_pkg::scan_t   judged;
    tfrf_pkg::scan_t   stepped;
    logic              in_fire;
    logic              out_load;
    logic              restart_cfg;

    assign in_stall     = (state_reg != tfrf_pkg::ST_RUN);
    assign in_fire      = in_valid && !in_stall;
    assign out_load     = (state_reg == tfrf_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
    assign restart_cfg  = cfg_we && (cfg_index == tfrf_pkg::CFG_START_ADDR);
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign region_start = region_start_reg;

    always_comb
    begin
        for (int i = 0; i < tfrf_pkg::WIN_BYTES; i++)
        begin
            entry_win[i] = (fill_reg == tfrf_pkg::fill_t'(i)) ? rom_byte : win_reg[i];
        end
        judge_win = (state_reg == tfrf_pkg::ST_RUN) ? entry_win : win_reg;
    end

    tfrf_judge u_judge (
        .cur        (scan_reg),
        .win        (judge_win),
        .full       (state_reg == tfrf_pkg::ST_RUN),
        .req_size   (req_size_reg),
        .aggressive (aggressive_reg),
        .nxt        (judged)
    );

    always_comb
    begin
        stepped     = judged;
        stepped.pos = scan_reg.pos + 1'b1;
        state_next  = state_reg;
        scan_next   = scan_reg;
        win_next    = win_reg;
        fill_next   = fill_reg;
        case (state_reg)
            tfrf_pkg::ST_RUN:
            begin
                if (restart_cfg)
                begin
                    scan_next     = '0;
                    scan_next.pos = cfg_data;
                    win_next      = '0;
                    fill_next     = '0;
                end
                else if (in_fire)
                begin
                    if (fill_reg == tfrf_pkg::fill_t'(tfrf_pkg::WIN_BYTES - 1))
                    begin
                        scan_next = stepped;
                        win_next  = entry_win >> 8;
                    end
                    else
                    begin
                        win_next  = entry_win;
                        fill_next = fill_reg + 1'b1;
                    end
                    if (last_byte)
                    begin
                        state_next = tfrf_pkg::ST_DRAIN;
                    end
                end
            end
            tfrf_pkg::ST_DRAIN:
            begin
                scan_next = stepped;
                win_next  = win_reg >> 8;
                fill_next = fill_reg - 1'b1;
                if (fill_reg == tfrf_pkg::fill_t'(1))
                begin
                    state_next = tfrf_pkg::ST_FINISH;
                end
            end
            tfrf_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    scan_next     = '0;
                    scan_next.pos = start_addr_reg;
                    win_next      = '0;
                    fill_next     = '0;
                    state_next    = tfrf_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = tfrf_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfrf_pkg::ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '{pos: tfrf_pkg::START_ADDR_RESET, run: '0, skip: '0,
                          done: 1'b0, maddr: '0};
            win_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_size_reg   <= tfrf_pkg::REQ_SIZE_RESET;
            start_addr_reg <= tfrf_pkg::START_ADDR_RESET;
            aggressive_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfrf_pkg::CFG_REQ_SIZE:
                begin
                    req_size_reg <= cfg_data[tfrf_pkg::SIZE_BITS-1:0];
                end
                tfrf_pkg::CFG_START_ADDR:
                begin
                    start_addr_reg <= cfg_data;
                end
                tfrf_pkg::CFG_AGGRESSIVE:
                begin
                    aggressive_reg <= cfg_data[0];
                end
                default:
                begin
                    aggressive_reg <= aggressive_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg        <= judged.done;
            region_start_reg <= judged.done ? judged.maddr : '0;
        end
    end

    `ASSERT_IMPLIES(a_beat_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg == tfrf_pkg::ST_FINISH))
    `ASSERT_IMPLIES(a_no_fit_zero_addr, clk, rst_n, out_valid_reg && !found_reg, region_start_reg == '0)
    `ASSERT_IMPLIES(a_drain_not_empty, clk, rst_n, state_reg == tfrf_pkg::ST_DRAIN, fill_reg != '0)
    `ASSERT_NEXT(a_restart_after_beat, clk, rst_n, out_load, (scan_reg.pos == $past(start_addr_reg)) && (fill_reg == '0) && !scan_reg.done)

endmodule

>>> tb/tb_tagged_free_run_finder_unit.sv
module tb_tagged_free_run_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tfrf_pkg::*;

    typedef struct {
        logic  found;
        addr_t start;
    } fit_t;

    typedef logic [7:0] image_q[$];

    class fit_scoreboard;
        size_t      req_size;
        addr_t      start_addr;
        logic       aggressive;
        addr_t      scan_pos;
        run_t       run_len;
        skip_t      skip_left;
        logic [7:0] look[WIN_BYTES];
        int         look_count;
        logic       have_fit;
        addr_t      fit_addr;
        fit_t       expected_fits[$];
        int         mismatches;
        int         fits_checked;

        function new();
            req_size = REQ_SIZE_RESET;
            start_addr = START_ADDR_RESET;
            aggressive = 1'b0;
            mismatches = 0;
            fits_checked = 0;
            rewind();
        endfunction

        function void rewind();
            scan_pos = start_addr;
            run_len = '0;
            skip_left = '0;
            foreach (look[i])
                look[i] = 8'h00;
            look_count = 0;
            have_fit = 1'b0;
            fit_addr = '0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_REQ_SIZE:   req_size = data[SIZE_BITS-1:0];
                CFG_START_ADDR:
                begin
                    start_addr = data;
                    rewind();
                end
                CFG_AGGRESSIVE: aggressive = data[0];
                default: ;
            endcase
        endfunction

        function int needed();
            return int'(req_size) + HEADER_BYTES;
        endfunction

        function void judge_oldest(bit full);
            logic [15:0] sz;
            logic [15:0] inv;
            if (have_fit)
                return;
            if (skip_left != 0)
            begin
                skip_left = skip_left - 1'b1;
                return;
            end
            if (run_len == needed())
            begin
                have_fit = 1'b1;
                fit_addr = scan_pos - addr_t'(needed());
                return;
            end
            if (scan_pos[BANK_BITS-1:0] == '0)
                run_len = '0;
            if (full && {look[3], look[2], look[1], look[0]} == TAG_MAGIC)
            begin
                sz = {look[5], look[4]};
                inv = {look[7], look[6]};
                if (sz != ~inv)
                begin
                    run_len = run_len + 1'b1;
                    return;
                end
                skip_left = skip_t'(sz) + skip_t'(8);
                run_len = '0;
                return;
            end
            if (look[0] == 8'h00 || aggressive)
                run_len = run_len + 1'b1;
            else
                run_len = '0;
        endfunction

        function void shift_window();
            for (int i = 0; i < WIN_BYTES - 1; i++)
                look[i] = look[i + 1];
            look[WIN_BYTES - 1] = 8'h00;
            if (look_count > 0)
                look_count--;
            scan_pos = scan_pos + 1'b1;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            fit_t fit;
            if (look_count > WIN_BYTES - 1)
                look_count = WIN_BYTES - 1;
            look[look_count] = b;
            look_count++;
            if (look_count == WIN_BYTES)
            begin
                judge_oldest(1'b1);
                shift_window();
            end
            if (!last)
                return;
            while (look_count > 0)
            begin
                judge_oldest(1'b0);
                shift_window();
            end
            if (!have_fit && skip_left == 0 && run_len == needed())
            begin
                have_fit = 1'b1;
                fit_addr = scan_pos - addr_t'(needed());
            end
            fit.found = have_fit;
            fit.start = have_fit ? fit_addr : '0;
            expected_fits.push_back(fit);
            rewind();
        endfunction

        function void check_fit(logic found, addr_t start);
            fit_t want;
            if (expected_fits.size() == 0)
            begin
                $display("%0t: result beat with none expected, found %0d region_start %h",
                         $time, found, start);
                mismatches++;
                return;
            end
            want = expected_fits.pop_front();
            fits_checked++;
            if (found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, want.found, found);
                mismatches++;
            end
            if (start !== want.start)
            begin
                $display("%0t: region_start mismatch, expected %h, actual %h",
                         $time, want.start, start);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_fits.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                rom_byte;
    logic                      last_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic                      found;
    addr_t                     region_start;

    fit_scoreboard sb;
    int            send_idle_pct = 10;
    int            recv_idle_pct = 10;
    bit            hold_request = 1'b0;
    int            items_sent = 0;

    tagged_free_run_finder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rom_byte     (rom_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .region_start (region_start)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_fit(found, region_start);
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int req, input addr_t start, input bit aggr);
        logic [CFG_DATA_BITS-1:0] noise;
        noise = CFG_DATA_BITS'($urandom);
        write_reg(CFG_REQ_SIZE, {noise[CFG_DATA_BITS-1:SIZE_BITS], size_t'(req)});
        write_reg(CFG_AGGRESSIVE, {noise[CFG_DATA_BITS-1:1], aggr});
        write_reg(CFG_START_ADDR, start);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rom_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    task automatic send_image(input image_q img);
        foreach (img[i])
            send_byte(img[i], i == img.size() - 1);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    function automatic image_q build_image(int need);
        image_q      img;
        int          target;
        int          kind;
        int          n;
        int          cap;
        logic [15:0] sz;
        logic [15:0] inv;
        cap = (need < 40) ? need + 2 : 40;
        target = (need <= 40) ? $urandom_range(1, 2 * need + 16) : $urandom_range(1, 60);
        while (img.size() < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                n = $urandom_range(1, cap);
                repeat (n) img.push_back(8'h00);
            end
            else if (kind == 4)
            begin
                n = $urandom_range(1, 3);
                repeat (n) img.push_back(8'($urandom));
            end
            else if (kind < 9)
            begin
                sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
                inv = ~sz;
                if (kind == 8)
                    inv = inv ^ 16'($urandom_range(1, 65535));
                for (int i = 0; i < 4; i++)
                    img.push_back(TAG_MAGIC[8*i +: 8]);
                img.push_back(sz[7:0]);
                img.push_back(sz[15:8]);
                img.push_back(inv[7:0]);
                img.push_back(inv[15:8]);
            end
            else
            begin
                n = $urandom_range(1, 7);
                for (int i = 0; i < n; i++)
                    img.push_back(i < 4 ? TAG_MAGIC[8*i +: 8] : 8'($urandom));
            end
        end
        while (img.size() > target)
            void'(img.pop_back());
        return img;
    endfunction

    initial
    begin
        int     phase;
        int     images;
        int     req;
        addr_t  start;
        bit     aggr;
        image_q img;

        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rom_byte = 8'h00;
        last_byte = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        img = {};
        repeat (9) img.push_back(8'h00);
        send_image(img);
        img = {TAG_MAGIC[7:0], TAG_MAGIC[15:8], TAG_MAGIC[23:16], TAG_MAGIC[31:24],
               8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        send_image(img);
        img = {TAG_MAGIC[7:0], TAG_MAGIC[15:8], TAG_MAGIC[23:16], TAG_MAGIC[31:24],
               8'h12, 8'h00};
        send_image(img);
        wait_idle();

        phase = 0;
        while (items_sent < 950 || sb.fits_checked < 40)
        begin
            send_idle_pct = 10;
            recv_idle_pct = 10;
            images = $urandom_range(2, 6);
            case (phase)
                0:
                begin
                    req = 0;
                    start = 24'h000000;
                    aggr = 1'b0;
                end
                1:
                begin
                    req = 32760;
                    start = 24'h123456;
                    aggr = 1'b1;
                end
                2:
                begin
                    req = 2;
                    start = 24'hFFFFF4;
                    aggr = 1'b0;
                end
                3:
                begin
                    req = 1;
                    start = addr_t'($urandom);
                    aggr = 1'b0;
                    images = 10;
                    hold_request = 1'b1;
                end
                4:
                begin
                    req = 3;
                    start = 24'h007FF6;
                    aggr = 1'b1;
                end
                5:
                begin
                    req = 1;
                    start = 24'hFFFFFF;
                    aggr = 1'b0;
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                6:
                begin
                    req = 5;
                    start = 24'h00FFF0;
                    aggr = 1'b0;
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                7:
                begin
                    req = 32767;
                    start = 24'hABCDEF;
                    aggr = 1'b1;
                end
                default:
                begin
                    req = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 20);
                    if ($urandom_range(0, 1) == 0)
                        start = addr_t'($urandom);
                    else
                        start = addr_t'(($urandom_range(1, 511) << BANK_BITS)
                                        - $urandom_range(0, 48));
                    aggr = $urandom_range(0, 1);
                end
            endcase
            configure(req, start, aggr);
            repeat (images)
            begin
                img = build_image(req + HEADER_BYTES);
                send_image(img);
            end
            wait_idle();
            phase++;
        end

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/tfrf_pkg.sv
design/tfrf_judge.sv
design/tagged_free_run_finder_unit.sv
tb/tb_tagged_free_run_finder_unit.sv
